FILE: src/ted_pkg.sv
package ted_pkg;

    // Encoding codes as they leave the block
    typedef enum logic [2:0] {
        ENC_UTF8     = 3'd0,
        ENC_UTF16LE  = 3'd1,
        ENC_UTF16BE  = 3'd2,
        ENC_UTF32LE  = 3'd3,
        ENC_UTF32BE  = 3'd4,
        ENC_ISO88591 = 3'd5,
        ENC_EBCDIC   = 3'd6
    } enc_t;

    // Byte order mark bytes
    localparam logic [7:0] BOM_EF = 8'hEF;
    localparam logic [7:0] BOM_BB = 8'hBB;
    localparam logic [7:0] BOM_BF = 8'hBF;
    localparam logic [7:0] BOM_FE = 8'hFE;
    localparam logic [7:0] BOM_FF = 8'hFF;

    // EBCDIC vote bytes: '<' and space in code page 037
    localparam logic [7:0] EBC_LT    = 8'h4C;
    localparam logic [7:0] EBC_SPACE = 8'h40;

    // Byte positions that bound the EBCDIC marks and the vote itself
    localparam int EBC_LT_SPAN    = 3;
    localparam int EBC_SPACE_SPAN = 10;
    localparam int EBC_CAP_SPAN   = 20;
    localparam int EBC_MIN_LEN    = 10;

    // UTF-8 lead and continuation prefixes
    localparam logic [1:0] U8_CONT  = 2'b10;
    localparam logic [2:0] U8_LEAD2 = 3'b110;
    localparam logic [3:0] U8_LEAD3 = 4'b1110;
    localparam logic [4:0] U8_LEAD4 = 5'b11110;

    // Flags and head bytes gathered over one text
    typedef struct packed {
        logic [3:0][7:0] head;
        logic [2:0]      marks;
        logic            high_seen;
        logic            broken;
    } flags_t;

    // Capital letters of code page 037
    function automatic logic is_ebcdic_capital(input logic [7:0] c);
        is_ebcdic_capital = c inside {[8'hC1:8'hC9], [8'hD1:8'hD9], [8'hE2:8'hE9]};
    endfunction

endpackage

FILE: src/ted_decide.sv
module ted_decide #(
    parameter int CW = 11
) (
    input  ted_pkg::flags_t flags,
    input  logic [CW-1:0]   n,
    input  logic [CW-1:0]   zeros,
    output ted_pkg::enc_t   code
);

    logic [CW+3:0] zeros_x10;
    logic          zero_major;
    logic          vote;
    logic [7:0]    h0;
    logic [7:0]    h1;
    logic [7:0]    h2;
    logic [7:0]    h3;

    assign h0 = flags.head[0];
    assign h1 = flags.head[1];
    assign h2 = flags.head[2];
    assign h3 = flags.head[3];

    // zeros > n / 10 holds exactly when 10 * zeros > n
    assign zeros_x10  = {1'b0, zeros, 3'b000} + {3'b000, zeros, 1'b0};
    assign zero_major = zeros_x10 > {4'b0000, n};

    // two of three marks win the vote
    assign vote = (flags.marks[0] & flags.marks[1]) | (flags.marks[0] & flags.marks[2])
                | (flags.marks[1] & flags.marks[2]);

    // priority order: byte order marks first, then EBCDIC vote, then zero counts, then UTF-8 check
    always_comb
    begin
        if (n >= CW'(3) && h0 == ted_pkg::BOM_EF && h1 == ted_pkg::BOM_BB
            && h2 == ted_pkg::BOM_BF)
        begin
            code = ted_pkg::ENC_UTF8;
        end
        else if (n >= CW'(4) && h0 == ted_pkg::BOM_FF && h1 == ted_pkg::BOM_FE
                 && h2 == 8'h00 && h3 == 8'h00)
        begin
            code = ted_pkg::ENC_UTF32LE;
        end
        else if (n >= CW'(4) && h0 == 8'h00 && h1 == 8'h00
                 && h2 == ted_pkg::BOM_FE && h3 == ted_pkg::BOM_FF)
        begin
            code = ted_pkg::ENC_UTF32BE;
        end
        else if (n >= CW'(2) && h0 == ted_pkg::BOM_FF && h1 == ted_pkg::BOM_FE)
        begin
            code = ted_pkg::ENC_UTF16LE;
        end
        else if (n >= CW'(2) && h0 == ted_pkg::BOM_FE && h1 == ted_pkg::BOM_FF)
        begin
            code = ted_pkg::ENC_UTF16BE;
        end
        else if (n >= CW'(ted_pkg::EBC_MIN_LEN) && vote)
        begin
            code = ted_pkg::ENC_EBCDIC;
        end
        else if (zero_major)
        begin
            if (n >= CW'(2) && h0 != 8'h00 && h1 == 8'h00)
            begin
                code = ted_pkg::ENC_UTF16LE;
            end
            else if (n >= CW'(2) && h0 == 8'h00 && h1 != 8'h00)
            begin
                code = ted_pkg::ENC_UTF16BE;
            end
            else
            begin
                code = ted_pkg::ENC_UTF32LE;
            end
        end
        else if (flags.high_seen && flags.broken)
        begin
            code = ted_pkg::ENC_ISO88591;
        end
        else
        begin
            code = ted_pkg::ENC_UTF8;
        end
    end

endmodule

FILE: src/text_encoding_detector.sv
// Text encoding detector.
// Input channel: one byte of a text per beat (text_byte) with final_byte
// marking the last byte; in_valid / in_stall handshake, taken when in_valid
// is high and in_stall is low.
// Output channel: one encoding_code per text, given for the final byte only;
// out_valid / out_stall handshake.
// Throughput: one byte per cycle while in_stall is low; every sampled byte
// updates counters and flags in constant work between the input register
// and the state/result registers. A final byte passes the input register,
// then the result register, before it is shown on out_valid.
// Stall: a waiting result holds steady; bytes that are not final keep
// flowing, and in_stall rises only when a final byte finds the result
// register still full and stalled.
// Reset: clears the text state and empties both registers; after each final
// byte the state returns to its reset values and the next byte opens a new
// text. Only the first SAMPLE_BYTES bytes feed the counters.
module text_encoding_detector #(
    parameter int SAMPLE_BYTES = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] encoding_code
);

    localparam int CW = $clog2(SAMPLE_BYTES + 1);
    localparam logic [CW-1:0] SAMPLE_CNT = CW'(SAMPLE_BYTES);

    logic            s1_valid_reg;
    logic [7:0]      s1_byte_reg;
    logic            s1_final_reg;
    logic            out_free;
    logic            s1_adv;

    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic [CW-1:0]   zeros_reg;
    logic [CW-1:0]   zeros_next;
    ted_pkg::flags_t flags_reg;
    ted_pkg::flags_t flags_next;
    logic [1:0]      owed_reg;
    logic [1:0]      owed_next;
    logic            in_sample;

    ted_pkg::enc_t   code_w;
    ted_pkg::enc_t   enc_reg;
    logic            out_valid_reg;

    // Handshake: input stage moves on unless a final byte meets a blocked result
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && (!s1_final_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_adv;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg  <= text_byte;
            s1_final_reg <= final_byte;
        end
    end

    // Fold the staged byte into the text state
    assign in_sample = cnt_reg < SAMPLE_CNT;

    always_comb
    begin
        cnt_next   = cnt_reg;
        zeros_next = zeros_reg;
        flags_next = flags_reg;
        owed_next  = owed_reg;
        if (in_sample)
        begin
            if (cnt_reg < CW'(4))
            begin
                flags_next.head[cnt_reg[1:0]] = s1_byte_reg;
            end
            if (cnt_reg < CW'(ted_pkg::EBC_LT_SPAN) && s1_byte_reg == ted_pkg::EBC_LT)
            begin
                flags_next.marks[0] = 1'b1;
            end
            if (cnt_reg < CW'(ted_pkg::EBC_SPACE_SPAN) && s1_byte_reg == ted_pkg::EBC_SPACE)
            begin
                flags_next.marks[1] = 1'b1;
            end
            if (cnt_reg < CW'(ted_pkg::EBC_CAP_SPAN)
                && ted_pkg::is_ebcdic_capital(s1_byte_reg))
            begin
                flags_next.marks[2] = 1'b1;
            end
            if (s1_byte_reg == 8'h00)
            begin
                zeros_next = zeros_reg + CW'(1);
            end
            else if (s1_byte_reg[7])
            begin
                flags_next.high_seen = 1'b1;
            end
            // UTF-8 lead / continuation check
            if (!flags_reg.broken)
            begin
                if (owed_reg != 2'd0)
                begin
                    if (s1_byte_reg[7:6] != ted_pkg::U8_CONT)
                    begin
                        flags_next.broken = 1'b1;
                    end
                    else
                    begin
                        owed_next = owed_reg - 2'd1;
                    end
                end
                else if (s1_byte_reg[7])
                begin
                    if (s1_byte_reg[7:5] == ted_pkg::U8_LEAD2)
                    begin
                        owed_next = 2'd1;
                    end
                    else if (s1_byte_reg[7:4] == ted_pkg::U8_LEAD3)
                    begin
                        owed_next = 2'd2;
                    end
                    else if (s1_byte_reg[7:3] == ted_pkg::U8_LEAD4)
                    begin
                        owed_next = 2'd3;
                    end
                    else
                    begin
                        flags_next.broken = 1'b1;
                    end
                end
            end
            cnt_next = cnt_reg + CW'(1);
        end
    end

    // Classify on the state that includes the staged byte
    ted_decide #(
        .CW (CW)
    ) u_decide (
        .flags (flags_next),
        .n     (cnt_next),
        .zeros (zeros_next),
        .code  (code_w)
    );

    // Text state: advance per byte, clear after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            zeros_reg <= '0;
            flags_reg <= '0;
            owed_reg  <= '0;
        end
        else if (s1_adv)
        begin
            if (s1_final_reg)
            begin
                cnt_reg   <= '0;
                zeros_reg <= '0;
                flags_reg <= '0;
                owed_reg  <= '0;
            end
            else
            begin
                cnt_reg   <= cnt_next;
                zeros_reg <= zeros_next;
                flags_reg <= flags_next;
                owed_reg  <= owed_next;
            end
        end
    end

    // Result register: load on the final byte, hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_adv && s1_final_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_final_reg)
        begin
            enc_reg <= code_w;
        end
    end

    assign out_valid     = out_valid_reg;
    assign encoding_code = enc_reg;

endmodule

FILE: src/ted_checker.sv
module ted_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       final_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] encoding_code
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(encoding_code))
        else $error("stalled result changed");

    // Input stalls only behind a blocked result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with result side free");

    // A byte that is not final never makes a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !final_byte) ##1 !out_valid |=> !out_valid)
        else $error("result without a final byte");

    // A taken final byte reaches the output through the input and result registers when the output is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && final_byte) ##1 (!out_valid || !out_stall)
        |=> out_valid)
        else $error("final byte gave no result");

    // Codes stay within the defined set
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> encoding_code != 3'd7)
        else $error("undefined encoding code");

endmodule

bind text_encoding_detector ted_checker u_ted_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .final_byte    (final_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .encoding_code (encoding_code)
);
